// File: rtl/amc_pkg.sv
// shared constants, codes and types of the address membership cache
`timescale 1ns / 1ps
package amc_pkg;

  localparam int AMC_BUCKETS    = 64;
  localparam int AMC_WAYS       = 16;
  localparam int AMC_BYTE_RANGE = 256;   // values of the bucket-select byte
  localparam int AMC_RECIP_SHIFT = 16;   // fraction bits of the bucket reciprocal

  localparam int AMC_ADDR_W = 32;
  localparam int AMC_FAM_W  = 16;
  localparam int AMC_KEY_W  = AMC_FAM_W + AMC_ADDR_W;

  localparam logic [7:0] AMC_BYTE_MASK = 8'hFF;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_META,
    S_DECODE,
    S_SCAN,
    S_RESP
  } state_t;

endpackage

// File: rtl/address_membership_cache.sv
// Address membership cache: remembers network addresses per bucket with
// first-in first-out replacement and answers membership lookups.
// Input channel in_*: one beat per command; in_tuser selects lookup or insert,
// in_tdata carries the address and its family. A lookup gives one out_* beat
// with the hit flag; an insert gives no beat.
// One command is worked at a time. An insert writes its entry and the bucket's
// fill count or ring start before the next command is taken. A lookup compares
// the bucket's filled ways in turn until a match or the last filled way
// (at most WAYS, 16 by default); the ways are read one per cycle through the
// single port of the entry memory, after the bucket index and then the
// bucket's fill count are registered.
// The hit sits in an output register: the next command is taken while it
// waits. If the receiver stalls and a second lookup finishes, that lookup
// waits for the register and no further command is taken meanwhile.
// Reset empties every bucket at once; stored entries are not cleared.
`timescale 1ns / 1ps
module address_membership_cache import amc_pkg::*; #(
  parameter int BUCKETS = AMC_BUCKETS,
  parameter int WAYS    = AMC_WAYS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] ip_address, [47:32] address_family
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] hit, [7:1] zero
);

  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int BKT_W   = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int WAY_W   = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int FILL_W  = $clog2(WAYS + 1);
  localparam int ADDR_W  = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

  state_t state_r, state_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 op_r;
  logic [AMC_KEY_W-1:0] key_r;
  logic [BKT_W-1:0]     bucket;
  logic [ADDR_W-1:0]    base_r;
  logic [FILL_W-1:0]    fill_r;
  logic [WAY_W-1:0]     way_r;
  logic                 hit_r;
  logic                 out_tvalid_r;
  logic                 out_hit_r;

  logic [FILL_W-1:0]    meta_fill;
  logic [WAY_W-1:0]     meta_start;
  logic                 meta_re;
  logic                 meta_we;
  logic [FILL_W-1:0]    meta_wfill;
  logic [WAY_W-1:0]     meta_wstart;

  logic                 ent_we;
  logic                 ent_re;
  logic [ADDR_W-1:0]    ent_addr;
  logic [AMC_KEY_W-1:0] ent_rdata;

  logic                 full;
  logic [WAY_W-1:0]     ins_way;
  logic [WAY_W-1:0]     start_inc;
  logic                 match;
  logic                 last_way;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_hit_r};

  amc_bucket_map #(
    .BUCKETS  (BUCKETS),
    .BKT_W    (BKT_W)
  ) u_map (
    .clk      (clk),
    .en       (in_acc),
    .addr_byte(in_tdata[7:0]),
    .bucket_r (bucket)
  );

  amc_meta_store #(
    .BUCKETS  (BUCKETS),
    .BKT_W    (BKT_W),
    .FILL_W   (FILL_W),
    .WAY_W    (WAY_W)
  ) u_meta (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (meta_re),
    .rd_bucket(bucket),
    .rd_fill  (meta_fill),
    .rd_start (meta_start),
    .wr_en    (meta_we),
    .wr_bucket(bucket),
    .wr_fill  (meta_wfill),
    .wr_start (meta_wstart)
  );

  amc_entry_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk    (clk),
    .we     (ent_we),
    .re     (ent_re),
    .addr   (ent_addr),
    .wdata  (key_r),
    .rdata_r(ent_rdata)
  );

  // insert bookkeeping: append while room is left, else replace the oldest
  assign full      = (meta_fill == FILL_W'(WAYS));
  assign ins_way   = full ? meta_start : meta_fill[WAY_W-1:0];
  assign start_inc = (meta_start == WAY_W'(WAYS - 1)) ? '0 : meta_start + WAY_W'(1);

  assign match    = (ent_rdata == key_r);
  assign last_way = ((FILL_W'(way_r) + FILL_W'(1)) == fill_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (op_r == OP_INSERT) begin
          state_nxt = S_IDLE;
        end else if (meta_fill == '0) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || last_way) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    meta_re     = 1'b0;
    meta_we     = 1'b0;
    meta_wfill  = meta_fill;
    meta_wstart = meta_start;
    ent_we      = 1'b0;
    ent_re      = 1'b0;
    ent_addr    = base_r;
    unique case (state_r)
      S_META: begin
        meta_re = 1'b1;
      end
      S_DECODE: begin
        if (op_r == OP_INSERT) begin
          ent_we   = 1'b1;
          ent_addr = base_r + ADDR_W'(ins_way);
          meta_we  = 1'b1;
          if (full) begin
            meta_wstart = start_inc;
          end else begin
            meta_wfill = meta_fill + FILL_W'(1);
          end
        end else if (meta_fill != '0) begin
          ent_re = 1'b1;
        end
      end
      S_SCAN: begin
        if (!(match || last_way)) begin
          ent_re   = 1'b1;
          ent_addr = base_r + ADDR_W'(way_r) + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser;
      key_r <= in_tdata;
    end
    if (state_r == S_META) begin
      base_r <= ADDR_W'(bucket) * ADDR_W'(WAYS);
    end
    if (state_r == S_DECODE) begin
      fill_r <= meta_fill;
      way_r  <= '0;
      hit_r  <= 1'b0;
    end
    if (state_r == S_SCAN) begin
      way_r <= way_r + WAY_W'(1);
      hit_r <= match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_RESP && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && out_free) begin
      out_hit_r <= hit_r;
    end
  end

endmodule

// File: rtl/amc_bucket_map.sv
// maps the low address byte to a bucket index, registered
`timescale 1ns / 1ps
module amc_bucket_map import amc_pkg::*; #(
  parameter int BUCKETS = AMC_BUCKETS,
  parameter int BKT_W   = 6
) (
  input  logic             clk,
  input  logic             en,
  input  logic [7:0]       addr_byte,
  output logic [BKT_W-1:0] bucket_r
);

  localparam int DIV   = (AMC_BYTE_RANGE / BUCKETS) == 0 ? 1 : AMC_BYTE_RANGE / BUCKETS;
  // rounded-up reciprocal, exact for every 8-bit numerator
  localparam int RECIP = ((1 << AMC_RECIP_SHIFT) + DIV - 1) / DIV;

  logic [24:0]      prod;
  logic [7:0]       quot;
  logic [BKT_W-1:0] bucket_nxt;

  assign prod = {17'd0, addr_byte & AMC_BYTE_MASK} * 25'(RECIP);
  assign quot = prod[AMC_RECIP_SHIFT +: 8];

  always_comb begin
    if ({1'b0, quot} >= 9'(BUCKETS)) begin
      bucket_nxt = BKT_W'(BUCKETS - 1);
    end else begin
      bucket_nxt = quot[BKT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bucket_r <= bucket_nxt;
    end
  end

endmodule

// File: rtl/amc_meta_store.sv
// per-bucket fill count and ring start, memory with reset-cleared valid bits
`timescale 1ns / 1ps
module amc_meta_store import amc_pkg::*; #(
  parameter int BUCKETS = AMC_BUCKETS,
  parameter int BKT_W   = 6,
  parameter int FILL_W  = 5,
  parameter int WAY_W   = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [BKT_W-1:0]  rd_bucket,
  output logic [FILL_W-1:0] rd_fill,
  output logic [WAY_W-1:0]  rd_start,
  input  logic              wr_en,
  input  logic [BKT_W-1:0]  wr_bucket,
  input  logic [FILL_W-1:0] wr_fill,
  input  logic [WAY_W-1:0]  wr_start
);

  localparam int MW = FILL_W + WAY_W;

  logic [MW-1:0]      mem [BUCKETS];
  logic [BUCKETS-1:0] vld_r;
  logic [MW-1:0]      rdata_r;
  logic               rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bucket] <= {wr_start, wr_fill};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_bucket] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_bucket];
      end
    end
  end

  // a bucket never written reads as empty
  assign rd_fill  = rvld_r ? rdata_r[FILL_W-1:0] : '0;
  assign rd_start = rvld_r ? rdata_r[MW-1:FILL_W] : '0;

endmodule

// File: rtl/amc_entry_ram.sv
// single-port entry memory holding family and address of every way
`timescale 1ns / 1ps
module amc_entry_ram import amc_pkg::*; #(
  parameter int DEPTH  = AMC_BUCKETS * AMC_WAYS,
  parameter int ADDR_W = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    addr,
  input  logic [AMC_KEY_W-1:0] wdata,
  output logic [AMC_KEY_W-1:0] rdata_r
);

  logic [AMC_KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

// File: tb/amc_checker.sv
// scoreboard for the address membership cache: predicts lookup hits and checks result beats
`timescale 1ns / 1ps
module amc_checker import amc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] ip_address, [47:32] address_family
  input  logic        in_tuser,   // [0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [0] hit, [7:1] zero
  output int          fail_count,
  output int          pending
);

  logic [AMC_KEY_W-1:0] way_key [AMC_BUCKETS][AMC_WAYS];
  int                   way_fill [AMC_BUCKETS];
  int                   ring_head [AMC_BUCKETS];
  logic                 hit_due [$];
  int                   errs = 0;

  function automatic int bucket_sel(input logic [AMC_ADDR_W-1:0] addr);
    int div;
    int b;
    div = AMC_BYTE_RANGE / AMC_BUCKETS;
    if (div == 0) div = 1;
    b = int'(addr[7:0] & AMC_BYTE_MASK) / div;
    // quotient can run past the last bucket when the count does not divide the byte range
    if (b >= AMC_BUCKETS) b = AMC_BUCKETS - 1;
    return b;
  endfunction

  always @(posedge clk) begin
    int                   b;
    logic [AMC_KEY_W-1:0] key;
    logic                 want_hit;
    logic                 found;
    if (!rst_n) begin
      for (int i = 0; i < AMC_BUCKETS; i++) begin
        way_fill[i]  = 0;
        ring_head[i] = 0;
      end
      hit_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (hit_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %02h",
                   $time, out_tdata);
          errs++;
        end else begin
          want_hit = hit_due.pop_front();
          if (out_tdata !== {7'b0000000, want_hit}) begin
            $display("%0t: hit mismatch, expected %02h, actual %02h",
                     $time, {7'b0000000, want_hit}, out_tdata);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        key = in_tdata[AMC_KEY_W-1:0];
        b   = bucket_sel(in_tdata[AMC_ADDR_W-1:0]);
        if (in_tuser == OP_LOOKUP) begin
          found = 1'b0;
          // only the filled ways are compared, oldest first
          for (int i = 0; i < way_fill[b]; i++) begin
            if (way_key[b][(ring_head[b] + i) % AMC_WAYS] == key) found = 1'b1;
          end
          hit_due.push_back(found);
        end else if (way_fill[b] < AMC_WAYS) begin
          way_key[b][way_fill[b]] = key;
          way_fill[b]++;
        end else begin
          // bucket full: replace the oldest and move the ring start on
          way_key[b][ring_head[b]] = key;
          ring_head[b] = (ring_head[b] + 1) % AMC_WAYS;
        end
      end
    end
    pending    <= hit_due.size();
    fail_count <= errs;
  end

endmodule

// File: tb/tb.sv
// top of the address membership cache testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb import amc_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_MAX    = 48;
  localparam logic [15:0] FAM_INET  = 16'd2;
  localparam logic [15:0] FAM_INET6 = 16'd10;
  localparam int SEND_IDLE  [4] = '{0, 57, 0, 24};
  localparam int RECV_STALL [4] = '{0, 0, 57, 24};
  localparam int HOT_BUCKET [4] = '{3, 17, 40, AMC_BUCKETS - 1};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;    // [31:0] ip_address, [47:32] address_family
  logic        in_tuser;    // [0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [0] hit, [7:1] zero

  int   fail_count;
  int   pending;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  bit   start_hold = 1'b0;
  int   cycle_cnt  = 0;
  logic [AMC_KEY_W-1:0] known_keys [$];

  always #5 clk = ~clk;

  address_membership_cache dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  amc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_cmd(input logic op, input logic [31:0] addr, input logic [15:0] fam);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {fam, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random back-pressure, plus one long hold-off
  initial begin
    bit hold_used;
    hold_used  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (start_hold && !hold_used) begin
        hold_used  = 1'b1;
        out_tready <= 1'b0;
        for (int left = HOLD_CYCLES; left > 0; left--) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    logic                 op;
    logic [31:0]          addr;
    logic [15:0]          fam;
    logic [AMC_KEY_W-1:0] pick;
    int                   roll;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = OP_LOOKUP;
    in_tdata  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty bucket, extremes, family and address near misses, duplicate insert
    send_cmd(OP_LOOKUP, 32'h0000_0000, 16'h0000);
    send_cmd(OP_INSERT, 32'h0000_0000, 16'h0000);
    send_cmd(OP_LOOKUP, 32'h0000_0000, 16'h0000);
    send_cmd(OP_LOOKUP, 32'h0000_0000, 16'h0001);
    send_cmd(OP_LOOKUP, 32'h0000_0100, 16'h0000);
    send_cmd(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFE);
    send_cmd(OP_LOOKUP, 32'h7FFF_FFFF, 16'hFFFF);
    send_cmd(OP_INSERT, 32'h0000_0000, 16'h0000);
    send_cmd(OP_LOOKUP, 32'h0000_0000, 16'h0000);
    send_cmd(OP_INSERT, 32'h8000_0004, FAM_INET);
    send_cmd(OP_LOOKUP, 32'h8000_0004, FAM_INET);
    send_cmd(OP_LOOKUP, 32'h0000_0004, FAM_INET);
    send_cmd(OP_LOOKUP, 32'h8000_0004, FAM_INET6);
    send_cmd(OP_INSERT, 32'h5555_5555, 16'hAAAA);
    send_cmd(OP_LOOKUP, 32'h5555_5555, 16'hAAAA);
    send_cmd(OP_INSERT, 32'hAAAA_AAAA, 16'h5555);
    send_cmd(OP_LOOKUP, 32'hAAAA_AAAA, 16'h5555);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = SEND_IDLE[ph];
      stall_pct = RECV_STALL[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 30) start_hold = 1'b1;
        roll = $urandom_range(99);
        if (roll < 45) begin
          // inserts crowd a few buckets so that they wrap and evict
          op   = OP_INSERT;
          addr = $urandom;
          if ($urandom_range(99) < 70) begin
            addr[7:0] = 8'(HOT_BUCKET[$urandom_range(3)] * (AMC_BYTE_RANGE / AMC_BUCKETS)
                           + $urandom_range(AMC_BYTE_RANGE / AMC_BUCKETS - 1));
          end
          if ($urandom_range(1) == 0) fam = $urandom_range(1) ? FAM_INET6 : FAM_INET;
          else fam = 16'($urandom);
          known_keys.push_back({fam, addr});
          if (known_keys.size() > POOL_MAX) void'(known_keys.pop_front());
        end else begin
          op   = OP_LOOKUP;
          addr = $urandom;
          fam  = 16'($urandom);
          if (known_keys.size() > 0 && roll < 85) begin
            pick = known_keys[$urandom_range(known_keys.size() - 1)];
            // near miss: one bit off above the bucket-select byte
            if (roll >= 75) pick[$urandom_range(AMC_KEY_W - 1, 8)] ^= 1'b1;
            addr = pick[AMC_ADDR_W-1:0];
            fam  = pick[AMC_KEY_W-1:AMC_ADDR_W];
          end else if ($urandom_range(1) == 0) begin
            addr[7:0] = 8'(HOT_BUCKET[$urandom_range(3)] * (AMC_BYTE_RANGE / AMC_BUCKETS));
          end
        end
        send_cmd(op, addr, fam);
      end
      // hold the sender until every lookup has answered
      in_tvalid <= 1'b0;
      @(negedge clk);
      while (pending != 0) @(negedge clk);
    end

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: address_membership_cache.f
rtl/amc_pkg.sv
rtl/amc_bucket_map.sv
rtl/amc_meta_store.sv
rtl/amc_entry_ram.sv
rtl/address_membership_cache.sv
tb/amc_checker.sv
tb/tb.sv
